[rtl/kmds_pkg.sv]
// ----------------------------------------------------------------------------
// kmds_pkg
// Shared types and constants of the key matrix debounce scanner.
// ----------------------------------------------------------------------------
package kmds_pkg;

	localparam int unsigned ROWS_DEF    = 8;
	localparam int unsigned COLS_DEF    = 16;
	localparam int unsigned HIST_W      = 8;
	localparam int unsigned DEPTH_W     = 4;
	localparam int unsigned SHIFT_W     = 4;
	localparam int unsigned TIME_W      = 16;
	localparam int unsigned IN_COLS     = 16;
	localparam int unsigned ROW_OUT_W   = 3;
	localparam int unsigned ST_OUT_W    = 16;
	localparam int unsigned S_TDATA_W   = 32;
	localparam int unsigned M_TDATA_W   = 40;

	localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd5;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 4'd8;
	localparam logic [SHIFT_W-1:0] SHIFT_FULL  = 4'd8;

	typedef struct packed {
		logic [HIST_W-1:0] hist;
		logic              set_key;
		logic              clr_key;
		logic              bounce;
	} lane_res_t;

	typedef struct packed {
		logic                 scanned;
		logic [ROW_OUT_W-1:0] row_index;
		logic [ST_OUT_W-1:0]  row_state;
		logic [ST_OUT_W-1:0]  bounce_mask;
		logic [ROW_OUT_W-1:0] next_row;
	} res_t;

endpackage

[rtl/kmds_lane.sv]
// ----------------------------------------------------------------------------
// kmds_lane
// One column: shifts the key history by the elapsed count and classifies it.
// ----------------------------------------------------------------------------
module kmds_lane (
	input  logic [kmds_pkg::HIST_W-1:0]  hist,
	input  logic                         sample,
	input  logic [kmds_pkg::SHIFT_W-1:0] shift,
	input  logic [kmds_pkg::DEPTH_W-1:0] depth,
	output kmds_pkg::lane_res_t          res
);
	import kmds_pkg::*;

	logic [2*HIST_W-1:0] ext;
	logic [2*HIST_W-1:0] shifted;
	logic [HIST_W-1:0]   h_new;
	logic [HIST_W-1:0]   mask;
	logic [HIST_W-1:0]   v;
	logic [HIST_W-1:0]   inv;
	logic                set_p;
	logic                hold_p;
	logic                clr_p;

	always_comb begin
		ext     = {hist, {HIST_W{sample}}};
		shifted = ext >> (SHIFT_FULL - shift);
		h_new   = shifted[HIST_W-1:0];
		mask    = HIST_W'((9'd1 << depth) - 9'd1);
		v       = h_new & mask;
		inv     = ~v & mask;
		clr_p   = (v == '0);
		set_p   = !clr_p && ((v & (v + HIST_W'(1))) == '0);
		hold_p  = !clr_p && !set_p && !v[0] && ((inv & (inv + HIST_W'(1))) == '0);
		res.hist    = h_new;
		res.set_key = set_p;
		res.clr_key = clr_p;
		res.bounce  = !clr_p && !set_p && !hold_p;
	end

endmodule

[rtl/kmds_merge.sv]
// ----------------------------------------------------------------------------
// kmds_merge
// Combines the lane decisions into the row's new key states and bounce mask.
// ----------------------------------------------------------------------------
module kmds_merge #(
	parameter int unsigned COLS = kmds_pkg::COLS_DEF
) (
	input  kmds_pkg::lane_res_t lanes [COLS],
	input  logic [COLS-1:0]     state_old,
	output logic [COLS-1:0]     state_new,
	output logic [COLS-1:0]     bounce
);
	import kmds_pkg::*;

	always_comb begin
		for (int i = 0; i < COLS; i++) begin
			state_new[i] = (state_old[i] | lanes[i].set_key) & ~lanes[i].clr_key;
			bounce[i]    = lanes[i].bounce;
		end
	end

endmodule

[rtl/key_matrix_debounce_scanner.sv]
// ----------------------------------------------------------------------------
// key_matrix_debounce_scanner
// Each result is registered in out_q, or in skid_q while out_q holds an unaccepted beat.
// Throughput: one beat per cycle while s_tready is high; all columns of a row update
// in parallel lanes with a single row-wide history read-modify-write in the accepting
// cycle when the elapsed time is nonzero. A two-entry output buffer keeps s_tready high
// while one result waits. Reset: asynchronous, clears histories, key states, timers and row;
// depth is 5.
module key_matrix_debounce_scanner #(
	parameter int unsigned ROWS = kmds_pkg::ROWS_DEF,
	parameter int unsigned COLS = kmds_pkg::COLS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [kmds_pkg::DEPTH_W-1:0]    cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [kmds_pkg::S_TDATA_W-1:0]  s_tdata,  // now_ms, col_bits
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [kmds_pkg::M_TDATA_W-1:0]  m_tdata,  // row_index, row_state,
	                                                  // bounce_mask, next_row, 0
	output logic                            m_tuser   // scanned
);
	import kmds_pkg::*;

	localparam int unsigned RW = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [DEPTH_W-1:0]          depth_q;
	logic [TIME_W-1:0]           pass_start_q;
	logic [TIME_W-1:0]           elapsed_q;
	logic [RW-1:0]               row_q;
	logic [COLS-1:0][HIST_W-1:0] hist_q [ROWS];
	logic [COLS-1:0]             state_q [ROWS];

	logic [TIME_W-1:0]           now_ms;
	logic [IN_COLS-1:0]          col_bits;
	logic                        push;
	logic                        pop;
	logic                        row0;
	logic [TIME_W-1:0]           elapsed_c;
	logic                        scan;
	logic [SHIFT_W-1:0]          shift;
	logic [DEPTH_W-1:0]          depth_eff;
	logic [RW-1:0]               row_nxt;
	logic [COLS-1:0][HIST_W-1:0] hist_rd;
	logic [COLS-1:0]             state_rd;
	logic [COLS-1:0]             state_new;
	logic [COLS-1:0]             bounce;
	lane_res_t                   lanes [COLS];
	res_t                        res_c;
	res_t                        out_q;
	res_t                        skid_q;
	logic                        out_valid_q;
	logic                        skid_valid_q;
	logic [31:0]                 state_ext;
	logic [31:0]                 bounce_ext;
	logic [7:0]                  row_ext;
	logic [7:0]                  nxt_ext;

	assign now_ms   = s_tdata[TIME_W-1:0];
	assign col_bits = s_tdata[TIME_W+IN_COLS-1:TIME_W];
	assign s_tready = !skid_valid_q;
	assign push     = s_tvalid && s_tready;
	assign pop      = out_valid_q && m_tready;

	always_comb begin
		row0      = (row_q == '0);
		elapsed_c = row0 ? (now_ms - pass_start_q) : elapsed_q;
		scan      = (elapsed_c != '0);
		if ((elapsed_c[7:0] == 8'd0) || (elapsed_c[7:0] > 8'(SHIFT_FULL))) begin
			shift = SHIFT_FULL;
		end else begin
			shift = SHIFT_W'(elapsed_c[7:0]);
		end
		if (depth_q == '0) begin
			depth_eff = DEPTH_W'(1);
		end else if (depth_q > DEPTH_MAX) begin
			depth_eff = DEPTH_MAX;
		end else begin
			depth_eff = depth_q;
		end
		row_nxt  = (row_q == RW'(ROWS - 1)) ? '0 : row_q + RW'(1);
		hist_rd  = hist_q[row_q];
		state_rd = state_q[row_q];
	end

	for (genvar i = 0; i < COLS; i++) begin : g_lane
		logic sample;
		if (i < IN_COLS) begin : g_in
			assign sample = col_bits[i];
		end else begin : g_zero
			assign sample = 1'b0;
		end
		kmds_lane u_lane (
			.hist   (hist_rd[i]),
			.sample (sample),
			.shift  (shift),
			.depth  (depth_eff),
			.res    (lanes[i])
		);
	end

	kmds_merge #(
		.COLS (COLS)
	) u_merge (
		.lanes     (lanes),
		.state_old (state_rd),
		.state_new (state_new),
		.bounce    (bounce)
	);

	always_comb begin
		state_ext  = 32'(scan ? state_new : state_rd);
		bounce_ext = 32'(scan ? bounce : '0);
		row_ext    = 8'(row_q);
		nxt_ext    = 8'(scan ? row_nxt : row_q);
		res_c.scanned     = scan;
		res_c.row_index   = row_ext[ROW_OUT_W-1:0];
		res_c.row_state   = state_ext[ST_OUT_W-1:0];
		res_c.bounce_mask = bounce_ext[ST_OUT_W-1:0];
		res_c.next_row    = nxt_ext[ROW_OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RESET;
		end else if (cfg_we) begin
			depth_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_start_q <= '0;
			elapsed_q    <= '0;
			row_q        <= '0;
			for (int r = 0; r < ROWS; r++) begin
				hist_q[r]  <= '0;
				state_q[r] <= '0;
			end
		end else if (push) begin
			if (row0) begin
				elapsed_q <= elapsed_c;
			end
			if (scan) begin
				if (row0) begin
					pass_start_q <= now_ms;
				end
				for (int i = 0; i < COLS; i++) begin
					hist_q[row_q][i] <= lanes[i].hist;
				end
				state_q[row_q] <= state_new;
				row_q          <= row_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= res_c;
			end else begin
				skid_q <= res_c;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.scanned;
	assign m_tdata  = {2'b00, out_q.next_row, out_q.bounce_mask, out_q.row_state,
		out_q.row_index};

	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("skid entry held without a pending output beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !m_tready |=> skid_valid_q)
		else $error("skid entry lost while output stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= RW'(ROWS - 1))
		else $error("row index out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		push && row0 && scan |=> pass_start_q == $past(now_ms))
		else $error("pass start time not latched on row 0");

endmodule
